/* rtl/core/li2s_pkg.sv */
// Shared types, constants and the dimension size helper for the index unravel core.
package li2s_pkg;

  localparam int unsigned IndexWidth    = 64;
  localparam int unsigned BoundWidth    = 32;
  localparam int unsigned SizeWidth     = BoundWidth + 1;
  localparam int unsigned DimCountWidth = 3;
  localparam int unsigned DimWidth      = 2;
  localparam int unsigned BoundRegs     = 4;
  localparam int unsigned CfgIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    CfgDimCount  = 3'd0,
    CfgBoundDim0 = 3'd1,
    CfgBoundDim1 = 3'd2,
    CfgBoundDim2 = 3'd3,
    CfgBoundDim3 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                 inverted;
    logic [SizeWidth-1:0] size;
  } dim_size_t;

  // size = upper - lower + 1 in 33 bits; inverted when upper < lower
  function automatic dim_size_t size_of(input logic [IndexWidth-1:0] bound);
    logic [SizeWidth-1:0] lo;
    logic [SizeWidth-1:0] hi;
    logic [SizeWidth-1:0] diff;
    dim_size_t            res;
    lo           = {bound[BoundWidth-1], bound[BoundWidth-1:0]};
    hi           = {bound[IndexWidth-1], bound[IndexWidth-1:BoundWidth]};
    diff         = hi - lo;
    res.inverted = diff[SizeWidth-1];
    res.size     = diff + SizeWidth'(1);
    return res;
  endfunction

endpackage

/* rtl/core/li2s_count.sv */
// Bit-serial element count: product of dimension sizes with overflow and inversion checks.
module li2s_count #(
  parameter int unsigned NumDims = 4,
  parameter int unsigned DimIdxW = 2
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  logic [li2s_pkg::DimCountWidth-1:0]               dims_i,
  input  logic [NumDims-1:0][li2s_pkg::IndexWidth-1:0]     bound_i,
  output logic                                             busy_o,
  output logic [li2s_pkg::IndexWidth-1:0]                  count_o
);

  localparam int unsigned BitW = $clog2(li2s_pkg::SizeWidth);

  logic                              start_q;
  logic                              busy_q, busy_d;
  logic                              zero_q, zero_d;
  logic [DimIdxW-1:0]                dim_q, dim_d;
  logic [BitW-1:0]                   bit_q, bit_d;
  logic [li2s_pkg::IndexWidth-1:0]   acc_q, acc_d;
  logic [li2s_pkg::IndexWidth-1:0]   prod_q, prod_d;

  li2s_pkg::dim_size_t               size;
  logic [li2s_pkg::IndexWidth:0]     sum;
  logic                              ovf;
  logic                              last_dim;

  assign size     = li2s_pkg::size_of(bound_i[dim_q]);
  // MSB-first shift-add: acc = 2*acc + bit * prod
  assign sum      = {1'b0, acc_q[li2s_pkg::IndexWidth-2:0], 1'b0}
                  + {1'b0, (size.size[bit_q] ? prod_q : '0)};
  assign ovf      = acc_q[li2s_pkg::IndexWidth-1] | sum[li2s_pkg::IndexWidth];
  assign last_dim = (li2s_pkg::DimCountWidth'(dim_q) == dims_i - 3'd1);

  // start in the cycle after the write so the new register values are seen
  always_comb begin
    busy_d = busy_q;
    zero_d = zero_q;
    dim_d  = dim_q;
    bit_d  = bit_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    if (start_q) begin
      busy_d = (dims_i != '0);
      zero_d = (dims_i == '0);
      dim_d  = '0;
      bit_d  = BitW'(li2s_pkg::SizeWidth - 1);
      acc_d  = '0;
      prod_d = li2s_pkg::IndexWidth'(1);
    end else if (busy_q) begin
      acc_d = sum[li2s_pkg::IndexWidth-1:0];
      if (ovf || size.inverted) begin
        zero_d = 1'b1;
      end
      if (bit_q == '0) begin
        prod_d = sum[li2s_pkg::IndexWidth-1:0];
        acc_d  = '0;
        bit_d  = BitW'(li2s_pkg::SizeWidth - 1);
        if (last_dim) begin
          busy_d = 1'b0;
        end else begin
          dim_d = dim_q + DimIdxW'(1);
        end
      end else begin
        bit_d = bit_q - BitW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
      busy_q  <= 1'b0;
      zero_q  <= 1'b1;
      dim_q   <= '0;
      bit_q   <= '0;
    end else begin
      start_q <= start_i;
      busy_q  <= busy_d;
      zero_q  <= zero_d;
      dim_q   <= dim_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign busy_o  = busy_q | start_q;
  assign count_o = zero_q ? '0 : prod_q;

endmodule

/* rtl/core/li2s_div.sv */
// Radix-2 restoring divider: 64-bit dividend by 33-bit size, one quotient bit per cycle.
module li2s_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [li2s_pkg::IndexWidth-1:0]      dividend_i,
  input  logic [li2s_pkg::SizeWidth-1:0]       divisor_i,
  output logic                                 done_o,
  output logic [li2s_pkg::IndexWidth-1:0]      quotient_o,
  output logic [li2s_pkg::BoundWidth-1:0]      remainder_o
);

  localparam int unsigned StepW = $clog2(li2s_pkg::IndexWidth);
  localparam int unsigned RemW  = li2s_pkg::SizeWidth;

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [StepW-1:0]                  cnt_q, cnt_d;
  logic [RemW-1:0]                   rem_q, rem_d;
  logic [li2s_pkg::IndexWidth-1:0]   quo_q, quo_d;
  logic [RemW-1:0]                   div_q, div_d;

  logic [RemW:0]                     trial;
  logic                              ge;

  assign trial = {rem_q, quo_q[li2s_pkg::IndexWidth-1]} - {1'b0, div_q};
  assign ge    = ~trial[RemW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 33 bits hold it
      rem_d = ge ? trial[RemW-1:0] : {rem_q[RemW-2:0], quo_q[li2s_pkg::IndexWidth-1]};
      quo_d = {quo_q[li2s_pkg::IndexWidth-2:0], ge};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == StepW'(li2s_pkg::IndexWidth - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[li2s_pkg::BoundWidth-1:0];

endmodule

/* rtl/core/linear_index_to_subscripts_core.sv */
// Top level: config registers, sequencer and output register of the index unravel core.
//
//  channel  | dir | beat carries
//  ---------+-----+--------------------------------------------------------------
//  s_axis   | in  | tdata[63:0] linear_index
//  m_axis   | out | tdata[31:0] subscript, tuser[0] in_range, tuser[2:1] dimension,
//           |     | tlast = last result of the index
//  cfg      | in  | cfg_index_i register index, cfg_data_i value
//
// An accepted index runs the 64-step radix-2 divider once per dimension in use, with a
// handoff between dimensions; a rejected index is answered without dividing. Each config
// write restarts the serial element-count multiplier: a registered setup step, then a
// bit-serial pass per dimension in use, and s_axis stalls until it ends.
// Reset zeroes the config registers (element count zero). A stalled m_axis holds the
// current beat and pauses the divider chain between dimensions.
module linear_index_to_subscripts_core #(
  parameter int unsigned MAX_DIMENSIONS = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [li2s_pkg::IndexWidth-1:0]         s_axis_tdata,   // [63:0] linear_index
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [li2s_pkg::BoundWidth-1:0]         m_axis_tdata,   // [31:0] subscript
  output logic [li2s_pkg::DimWidth:0]             m_axis_tuser,   // [0] in_range, [2:1] dimension
  output logic                                    m_axis_tlast,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [li2s_pkg::CfgIndexWidth-1:0]      cfg_index_i,
  input  logic [li2s_pkg::IndexWidth-1:0]         cfg_data_i
);

  localparam int unsigned NumDims = (MAX_DIMENSIONS < li2s_pkg::BoundRegs) ?
                                    MAX_DIMENSIONS : li2s_pkg::BoundRegs;
  localparam int unsigned DimIdxW = (NumDims > 1) ? $clog2(NumDims) : 1;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StDivide = 3'b010,
    StEmit   = 3'b100
  } state_e;

  state_e                                       state_q, state_d;
  logic [li2s_pkg::DimCountWidth-1:0]           dim_count_q;
  logic [NumDims-1:0][li2s_pkg::IndexWidth-1:0] bound_q;
  logic [DimIdxW-1:0]                           dim_q, dim_d;

  logic                                         out_valid_q, out_valid_d;
  logic                                         out_range_q, out_range_d;
  logic [li2s_pkg::DimWidth-1:0]                out_dim_q, out_dim_d;
  logic [li2s_pkg::BoundWidth-1:0]              out_sub_q, out_sub_d;
  logic                                         out_last_q, out_last_d;

  logic [li2s_pkg::DimCountWidth-1:0]           active_dims;
  logic [li2s_pkg::CfgIndexWidth-1:0]           bound_sel;
  logic                                         cfg_we;
  logic                                         count_busy;
  logic [li2s_pkg::IndexWidth-1:0]              count;
  logic                                         out_free;
  logic                                         in_accept;
  logic                                         reject;

  logic                                         div_start;
  logic [DimIdxW-1:0]                           div_dim;
  logic [li2s_pkg::IndexWidth-1:0]              div_dividend;
  li2s_pkg::dim_size_t                          div_size;
  logic                                         div_done;
  logic [li2s_pkg::IndexWidth-1:0]              div_quo;
  logic [li2s_pkg::BoundWidth-1:0]              div_rem;

  // ---- configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign bound_sel   = cfg_index_i - li2s_pkg::CfgIndexWidth'(li2s_pkg::CfgBoundDim0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= '0;
      bound_q     <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == li2s_pkg::CfgDimCount) begin
        dim_count_q <= cfg_data_i[li2s_pkg::DimCountWidth-1:0];
      end
      for (int unsigned d = 0; d < NumDims; d++) begin
        if (cfg_index_i != li2s_pkg::CfgDimCount &&
            bound_sel == li2s_pkg::CfgIndexWidth'(d)) begin
          bound_q[d] <= cfg_data_i;
        end
      end
    end
  end

  assign active_dims = (dim_count_q > li2s_pkg::DimCountWidth'(NumDims)) ?
                       li2s_pkg::DimCountWidth'(NumDims) : dim_count_q;

  li2s_count #(
    .NumDims (NumDims),
    .DimIdxW (DimIdxW)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we),
    .dims_i  (active_dims),
    .bound_i (bound_q),
    .busy_o  (count_busy),
    .count_o (count)
  );

  // ---- sequencer
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) & ~count_busy & out_free;
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign reject        = (s_axis_tdata >= count);

  assign div_dim      = (state_q == StIdle) ? DimIdxW'(active_dims - 3'd1)
                                            : dim_q - DimIdxW'(1);
  assign div_dividend = (state_q == StIdle) ? s_axis_tdata : div_quo;
  assign div_size     = li2s_pkg::size_of(bound_q[div_dim]);

  always_comb begin
    state_d     = state_q;
    dim_d       = dim_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_range_d = out_range_q;
    out_dim_d   = out_dim_q;
    out_sub_d   = out_sub_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          if (reject) begin
            out_valid_d = 1'b1;
            out_range_d = 1'b0;
            out_dim_d   = '0;
            out_sub_d   = '0;
            out_last_d  = 1'b1;
          end else begin
            div_start = 1'b1;
            dim_d     = div_dim;
            state_d   = StDivide;
          end
        end
      end
      StDivide: begin
        if (div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_range_d = 1'b1;
          out_dim_d   = li2s_pkg::DimWidth'(dim_q);
          out_sub_d   = bound_q[dim_q][li2s_pkg::BoundWidth-1:0] + div_rem;
          out_last_d  = (dim_q == '0);
          if (dim_q == '0) begin
            state_d = StIdle;
          end else begin
            // quotient of this dimension feeds the next one down
            div_start = 1'b1;
            dim_d     = div_dim;
            state_d   = StDivide;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  li2s_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_size.size),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      dim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dim_q       <= dim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_range_q <= out_range_d;
    out_dim_q   <= out_dim_d;
    out_sub_q   <= out_sub_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sub_q;
  assign m_axis_tuser  = {out_dim_q, out_range_q};
  assign m_axis_tlast  = out_last_q;

endmodule

/* sim/tb.sv */
// Testbench for linear_index_to_subscripts_core: directed and random unravel checks.
`timescale 1ns / 1ps

module tb;

  localparam int MaxDims = 4;
  // Register indexes past the last bound register are spare; writes there are dropped.
  localparam logic [li2s_pkg::CfgIndexWidth-1:0] CfgSpareFirst = 3'd5;
  localparam logic [li2s_pkg::CfgIndexWidth-1:0] CfgSpareLast  = 3'd7;

  typedef struct packed {
    logic                          in_range;
    logic [li2s_pkg::DimWidth-1:0] dimension;
    logic [31:0]                   subscript;
    logic                          last;
  } subscript_beat_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [li2s_pkg::IndexWidth-1:0]    s_axis_tdata;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [li2s_pkg::BoundWidth-1:0]    m_axis_tdata;
  logic [li2s_pkg::DimWidth:0]        m_axis_tuser;
  logic                               m_axis_tlast;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [li2s_pkg::CfgIndexWidth-1:0] cfg_index_i;
  logic [li2s_pkg::IndexWidth-1:0]    cfg_data_i;

  // slice configuration as the block should hold it
  logic [li2s_pkg::DimCountWidth-1:0] slice_dims;
  logic [li2s_pkg::IndexWidth-1:0]    slice_bounds[li2s_pkg::BoundRegs];

  subscript_beat_t expected_beats[$];
  int              mismatch_count;
  int              src_idle_pct;
  int              snk_idle_pct;

  linear_index_to_subscripts_core #(
    .MAX_DIMENSIONS(MaxDims)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int active_dims();
    int n;
    n = int'(slice_dims);
    if (n > MaxDims) n = MaxDims;
    if (n > int'(li2s_pkg::BoundRegs)) n = int'(li2s_pkg::BoundRegs);
    return n;
  endfunction

  // upper - lower + 1 in 1..2^32, zero for an inverted range
  function automatic logic [32:0] dim_extent(input logic [li2s_pkg::IndexWidth-1:0] bound);
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] span;
    lo   = {{2{bound[31]}}, bound[31:0]};
    hi   = {{2{bound[63]}}, bound[63:32]};
    span = hi - lo + 34'sd1;
    if (span[33] || span == 0) return '0;
    return span[32:0];
  endfunction

  function automatic logic [li2s_pkg::IndexWidth-1:0] element_count();
    logic [127:0] prod;
    logic [32:0]  s;
    int           n;
    n    = active_dims();
    prod = 128'd1;
    if (n == 0) return '0;
    for (int d = 0; d < n; d++) begin
      s = dim_extent(slice_bounds[d]);
      if (s == 0) return '0;
      prod = prod * s;
      if (prod[127:64] != 0) return '0;
    end
    return prod[63:0];
  endfunction

  function automatic void unravel_index(input logic [li2s_pkg::IndexWidth-1:0] idx);
    logic [li2s_pkg::IndexWidth-1:0] rem;
    logic [li2s_pkg::IndexWidth-1:0] r;
    logic [32:0]                     s;
    subscript_beat_t                 b;
    int                              n;
    n = active_dims();
    if (idx >= element_count()) begin
      b = '{in_range: 1'b0, dimension: '0, subscript: '0, last: 1'b1};
      expected_beats.push_back(b);
      return;
    end
    rem = idx;
    for (int d = n - 1; d >= 0; d--) begin
      s   = dim_extent(slice_bounds[d]);
      r   = rem % s;
      rem = rem / s;
      b.in_range  = 1'b1;
      b.dimension = d[li2s_pkg::DimWidth-1:0];
      b.subscript = slice_bounds[d][31:0] + r[31:0];
      b.last      = (d == 0);
      expected_beats.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    subscript_beat_t exp_b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected beat: subscript %0d dimension %0d", $signed(m_axis_tdata),
               m_axis_tuser[2:1]);
        mismatch_count++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (m_axis_tuser[0] !== exp_b.in_range) begin
          $error("in_range: expected %0d, got %0d", exp_b.in_range, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tuser[2:1] !== exp_b.dimension) begin
          $error("dimension: expected %0d, got %0d", exp_b.dimension, m_axis_tuser[2:1]);
          mismatch_count++;
        end
        if (m_axis_tdata !== exp_b.subscript) begin
          $error("subscript: expected %0d, got %0d", $signed(exp_b.subscript),
                 $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tlast !== exp_b.last) begin
          $error("last: expected %0d, got %0d", exp_b.last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // ---------------------------------------------------------------- drivers

  // Valid stays high after acceptance; the next call either reloads or drops it.
  task automatic send_index(input logic [li2s_pkg::IndexWidth-1:0] idx);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    unravel_index(idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Only written with the block idle: stream stopped and every result back.
  task automatic write_reg(input logic [li2s_pkg::CfgIndexWidth-1:0] index,
                           input logic [li2s_pkg::IndexWidth-1:0] value);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (li2s_pkg::cfg_reg_e'(index))
      li2s_pkg::CfgDimCount:  slice_dims      = value[li2s_pkg::DimCountWidth-1:0];
      li2s_pkg::CfgBoundDim0: slice_bounds[0] = value;
      li2s_pkg::CfgBoundDim1: slice_bounds[1] = value;
      li2s_pkg::CfgBoundDim2: slice_bounds[2] = value;
      li2s_pkg::CfgBoundDim3: slice_bounds[3] = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [li2s_pkg::IndexWidth-1:0] make_bound(input logic [31:0] lo,
                                                                 input logic [31:0] hi);
    return {hi, lo};
  endfunction

  function automatic logic [li2s_pkg::IndexWidth-1:0] rand_bound(input bit well_formed);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    hi = $urandom;
    if (well_formed) begin
      if ($urandom_range(9) == 0) begin
        // wide dimension: lower <= 0 <= upper
        lo     = -$urandom_range(1000);
        hi[31] = 1'b0;
      end else begin
        if ($signed(lo) > 32'sh7fff_fff0) lo = 32'h7fff_fff0;
        hi = lo + $urandom_range(15);
      end
    end else if ($urandom_range(3) == 0) begin
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
    end
    return make_bound(lo, hi);
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_empty_slice();
    send_index('0);
    send_index('1);
    write_reg(li2s_pkg::CfgDimCount, 64'd1);
    send_index('0);
    send_index(64'd1);
  endtask

  task automatic test_full_span();
    write_reg(li2s_pkg::CfgBoundDim0, make_bound(32'h8000_0000, 32'h7fff_ffff));
    send_index('0);
    send_index(64'hffff_ffff);
    send_index(64'h1_0000_0000);
  endtask

  task automatic test_product_overflow();
    // 2^32 * 2^32 is one past the 64-bit range
    write_reg(li2s_pkg::CfgBoundDim1, make_bound(32'h8000_0000, 32'h7fff_ffff));
    write_reg(li2s_pkg::CfgDimCount, 64'd2);
    send_index('0);
    write_reg(li2s_pkg::CfgBoundDim1, make_bound(32'h8000_0001, 32'h7fff_ffff));
    send_index(64'hffff_fffe_ffff_ffff);
    send_index('1);
  endtask

  task automatic test_inverted_range();
    write_reg(li2s_pkg::CfgBoundDim2, make_bound(32'd5, 32'd4));
    write_reg(li2s_pkg::CfgDimCount, 64'd3);
    send_index('0);
    write_reg(li2s_pkg::CfgBoundDim2, make_bound(32'h7fff_ffff, 32'h8000_0000));
    send_index('0);
  endtask

  task automatic test_saturated_dims();
    write_reg(li2s_pkg::CfgBoundDim0, make_bound(-32'sd3, -32'sd1));
    write_reg(li2s_pkg::CfgBoundDim1, '1);
    write_reg(li2s_pkg::CfgBoundDim2, make_bound(32'd0, 32'd4));
    write_reg(li2s_pkg::CfgBoundDim3, make_bound(32'h7fff_fffa, 32'h7fff_ffff));
    write_reg(li2s_pkg::CfgDimCount, 64'd7);
    for (int i = CfgSpareFirst; i <= CfgSpareLast; i++) write_reg(i[2:0], '1);
    send_index('0);
    send_index(64'd89);
    send_index(64'd90);
    send_index(64'd45);
    write_reg(li2s_pkg::CfgDimCount, 64'd4);
    send_index(64'd17);
  endtask

  task automatic pick_slice();
    logic [li2s_pkg::IndexWidth-1:0] dims_word;
    bit                              well_formed;
    well_formed = ($urandom_range(99) < 80);
    dims_word   = {$urandom, $urandom};
    if (well_formed) begin
      dims_word[li2s_pkg::DimCountWidth-1:0] =
        li2s_pkg::DimCountWidth'($urandom_range(1, MaxDims));
    end
    write_reg(li2s_pkg::CfgDimCount, dims_word);
    write_reg(li2s_pkg::CfgBoundDim0, rand_bound(well_formed));
    write_reg(li2s_pkg::CfgBoundDim1, rand_bound(well_formed));
    write_reg(li2s_pkg::CfgBoundDim2, rand_bound(well_formed));
    write_reg(li2s_pkg::CfgBoundDim3, rand_bound(well_formed));
    if ($urandom_range(19) == 0)
      write_reg(li2s_pkg::CfgIndexWidth'($urandom_range(CfgSpareFirst, CfgSpareLast)),
                {$urandom, $urandom});
  endtask

  task automatic test_random_slices(input int n_items);
    logic [li2s_pkg::IndexWidth-1:0] count;
    logic [li2s_pkg::IndexWidth-1:0] idx;
    int                              sent;
    int                              burst;
    sent = 0;
    while (sent < n_items) begin
      pick_slice();
      count = element_count();
      burst = $urandom_range(5, 15);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        if (count != 0 && $urandom_range(99) < 85) begin
          case ($urandom_range(9))
            0:       idx = count - 1;
            1, 2, 3: idx = 64'($urandom_range(63)) % count;
            default: idx = {$urandom, $urandom} % count;
          endcase
        end else begin
          case ($urandom_range(3))
            0:       idx = count;
            1:       idx = '1;
            default: idx = {$urandom, $urandom};
          endcase
        end
        send_index(idx);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = li2s_pkg::CfgDimCount;
    cfg_data_i     = '0;
    mismatch_count = 0;
    src_idle_pct   = 32;
    snk_idle_pct   = 79;
    slice_dims     = '0;
    for (int d = 0; d < li2s_pkg::BoundRegs; d++) slice_bounds[d] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_slice();
    test_full_span();
    test_product_overflow();
    test_inverted_range();
    test_saturated_dims();
    test_random_slices(87);
    src_idle_pct = 79;
    snk_idle_pct = 32;
    test_random_slices(87);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_slices(86);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/li2s_pkg.sv
rtl/core/li2s_count.sv
rtl/core/li2s_div.sv
rtl/core/linear_index_to_subscripts_core.sv
sim/tb.sv
